FILE: hdl/echo_median_spike_limiter_core_assert.svh
// Assertion macros used by the echo median spike limiter top level.
`ifndef ECHO_MEDIAN_SPIKE_LIMITER_CORE_ASSERT_SVH
`define ECHO_MEDIAN_SPIKE_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EMS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("echo median spike limiter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define EMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("echo median spike limiter: next-cycle check failed");

`endif

FILE: hdl/ems_pkg.sv
// Shared types and constants of the echo median spike limiter.
package ems_pkg;

   localparam int DIST_W = 13;
   localparam int ECHO_W = 15;
   localparam int GAIN_W = 9;
   localparam int MINV_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [10:0] DIST_SCALE = 11'd1114;
   localparam int DIST_SHIFT = 12;
   localparam logic [DIST_W-1:0] DIST_LIMIT = 13'd8191;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLLOW_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID = 3'd4;

   localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 13'd32;
   localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 13'd6400;
   localparam logic [DIST_W-1:0] SPIKE_THRESHOLD_RST = 13'd80;
   localparam logic [GAIN_W-1:0] FOLLOW_GAIN_RST = 9'd179;
   localparam logic [MINV_W-1:0] MIN_VALID_RST = 3'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [DIST_W-1:0] min_distance;
      logic [DIST_W-1:0] max_distance;
      logic [DIST_W-1:0] spike_threshold;
      logic [GAIN_W-1:0] follow_gain;
      logic [MINV_W-1:0] min_valid;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              keep;
      logic              last;
   } entry_type;

endpackage

FILE: hdl/echo_median_spike_limiter_core.sv
// Top level of the echo median spike limiter: registers, front, queue and back end.
//
// Each req beat carries one echo width in microseconds (zero means no echo). The front
// end turns it into a distance in 1/16 cm, range checks it and places it in a two-entry
// queue in the cycle the beat is accepted, so beats go in one per cycle while the queue
// has room. Every SAMPLES_PER_GROUP beats close a group, and the group gives one rsp beat
// with the filtered distance, a held flag and the count of in-range samples.
// The back end takes one queued sample per cycle while it waits in its pop state. A held
// group goes from its closing sample straight to the emit state; otherwise the back end
// ranks each kept sample in turn, then multiplies, then limits the step, and the rsp beat
// is registered in the emit state. The ranking loop grows with the number of kept samples.
// The rsp output is a register: while the receiver stalls, the back end keeps consuming
// samples and stops only when the next result is ready to leave. Configuration is written
// through csr_we, csr_index and csr_wdata, by the user only while the block is idle; the
// block itself does not enforce this. Synchronous reset restores the register defaults,
// clears the queue, group position, kept count and last distance, and drops rsp_valid.
module echo_median_spike_limiter_core #(
   parameter int SAMPLES_PER_GROUP = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ems_pkg::ECHO_W-1:0]      req_echo_us,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ems_pkg::DIST_W-1:0]      rsp_distance,
   output logic                            rsp_held,
   output logic [2:0]                      rsp_valid_count,
   input  logic                            csr_we,
   input  logic [ems_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ems_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ems_pkg::cfg_type   cfg_ff;
   ems_pkg::entry_type push_entry;
   ems_pkg::entry_type pop_entry;
   logic               push_valid;
   logic               push_ready;
   logic               pop_valid;
   logic               pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance <= ems_pkg::MIN_DISTANCE_RST;
         cfg_ff.max_distance <= ems_pkg::MAX_DISTANCE_RST;
         cfg_ff.spike_threshold <= ems_pkg::SPIKE_THRESHOLD_RST;
         cfg_ff.follow_gain <= ems_pkg::FOLLOW_GAIN_RST;
         cfg_ff.min_valid <= ems_pkg::MIN_VALID_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ems_pkg::CSR_MIN_DISTANCE: cfg_ff.min_distance <= csr_wdata;
            ems_pkg::CSR_MAX_DISTANCE: cfg_ff.max_distance <= csr_wdata;
            ems_pkg::CSR_SPIKE_THRESHOLD: cfg_ff.spike_threshold <= csr_wdata;
            ems_pkg::CSR_FOLLOW_GAIN: begin
               cfg_ff.follow_gain <= csr_wdata[ems_pkg::GAIN_W-1:0];
            end
            ems_pkg::CSR_MIN_VALID: begin
               cfg_ff.min_valid <= csr_wdata[ems_pkg::MINV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   ems_front #(
      .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_echo_us(req_echo_us),
      .cfg(cfg_ff),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry)
   );

   ems_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_entry(pop_entry)
   );

   ems_back #(
      .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_entry(pop_entry),
      .cfg(cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance),
      .rsp_held(rsp_held),
      .rsp_valid_count(rsp_valid_count)
   );

`include "echo_median_spike_limiter_core_assert.svh"

   `EMS_ASSERT_NOW(a_fresh_median_has_enough, clock, reset,
      rsp_valid && !rsp_held && (SAMPLES_PER_GROUP < 8),
      (rsp_valid_count != 3'd0) && (rsp_valid_count >= cfg_ff.min_valid))
   `EMS_ASSERT_NEXT(a_one_beat_per_emit, clock, reset,
      rsp_valid && rsp_ready, !rsp_valid)

endmodule

FILE: hdl/ems_front.sv
// Front end: converts echo widths to distances, range checks them and tags group ends.
module ems_front #(
   parameter int SAMPLES_PER_GROUP = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ems_pkg::ECHO_W-1:0]  req_echo_us,
   input  ems_pkg::cfg_type            cfg,
   output logic                        push_valid,
   input  logic                        push_ready,
   output ems_pkg::entry_type          push_entry
);

   localparam int PW = $clog2(SAMPLES_PER_GROUP);
   localparam int PROD_W = ems_pkg::ECHO_W + 11;

   logic [PW-1:0]     pos_ff;
   logic [PW-1:0]     pos_in;
   logic [PROD_W-1:0] product;
   logic [PROD_W-ems_pkg::DIST_SHIFT-1:0] dist_full;
   logic              last;
   logic              accept;

   always_comb begin
      product = PROD_W'(req_echo_us) * PROD_W'(ems_pkg::DIST_SCALE);
      dist_full = product[PROD_W-1:ems_pkg::DIST_SHIFT];
      last = (pos_ff == PW'(SAMPLES_PER_GROUP - 1));
      accept = req_valid && push_ready;
      pos_in = pos_ff;
      if (accept) begin
         pos_in = last ? '0 : pos_ff + PW'(1);
      end
   end

   assign req_ready = push_ready;
   assign push_valid = req_valid;
   assign push_entry.distance = dist_full[ems_pkg::DIST_W-1:0];
   assign push_entry.keep = (dist_full > {1'b0, cfg.min_distance})
                         && (dist_full < {1'b0, cfg.max_distance});
   assign push_entry.last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: hdl/ems_queue.sv
// Small FIFO of classified samples between the front and back ends.
module ems_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ems_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ems_pkg::entry_type pop_entry
);

   ems_pkg::entry_type                 entry_ff [ems_pkg::QUEUE_DEPTH];
   logic [ems_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [ems_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [ems_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != ems_pkg::QUEUE_CNT_W'(ems_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + ems_pkg::QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + ems_pkg::QUEUE_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + ems_pkg::QUEUE_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - ems_pkg::QUEUE_CNT_W'(1);
         end
      end
   end

endmodule

FILE: hdl/ems_back.sv
// Back end: stores kept samples, ranks them for the upper median and limits the step, or holds the last distance.
module ems_back #(
   parameter int SAMPLES_PER_GROUP = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  ems_pkg::entry_type          pop_entry,
   input  ems_pkg::cfg_type            cfg,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ems_pkg::DIST_W-1:0]  rsp_distance,
   output logic                        rsp_held,
   output logic [2:0]                  rsp_valid_count
);

   localparam int PW = $clog2(SAMPLES_PER_GROUP);
   localparam int KW = $clog2(SAMPLES_PER_GROUP + 1);
   localparam int CW = (KW > ems_pkg::MINV_W) ? KW : ems_pkg::MINV_W;
   localparam int DW = ems_pkg::DIST_W;

   typedef enum logic [2:0] {
      ST_POP,
      ST_RANK,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [DW-1:0]        store_ff [SAMPLES_PER_GROUP];
   logic [KW-1:0]        kept_ff;
   logic [KW-1:0]        cnt_ff;
   logic [PW-1:0]        idx_ff;
   logic [DW-1:0]        last_ff;
   logic [DW-1:0]        med_ff;
   logic signed [23:0]   prod_ff;
   logic                 bypass_ff;
   logic [DW-1:0]        result_ff;
   logic                 held_ff;
   logic                 rsp_valid_ff;
   logic [DW-1:0]        rsp_distance_ff;
   logic                 rsp_held_ff;
   logic [2:0]           rsp_count_ff;

   logic                 take_sample;
   logic [KW-1:0]        kept_next;
   logic                 too_few;
   logic [DW-1:0]        cand;
   logic [KW-1:0]        rank;
   logic                 rank_done;
   logic [DW-1:0]        mag;
   logic signed [13:0]   diff;
   logic signed [9:0]    gain_s;
   logic signed [15:0]   step;
   logic signed [17:0]   sum;
   logic [DW-1:0]        sat;

   assign pop_ready = (state_ff == ST_POP);

   always_comb begin
      take_sample = pop_entry.keep && (kept_ff < KW'(SAMPLES_PER_GROUP));
      kept_next = take_sample ? kept_ff + KW'(1) : kept_ff;
      too_few = (kept_next == '0) || (CW'(kept_next) < CW'(cfg.min_valid));

      cand = store_ff[idx_ff];
      rank = '0;
      for (int j = 0; j < SAMPLES_PER_GROUP; j++) begin
         if ((KW'(j) < cnt_ff) && ((store_ff[j] < cand)
             || ((store_ff[j] == cand) && (PW'(j) < idx_ff)))) begin
            rank = rank + KW'(1);
         end
      end
      rank_done = ((KW'(idx_ff) + KW'(1)) == cnt_ff);

      mag = (med_ff > last_ff) ? med_ff - last_ff : last_ff - med_ff;
      diff = $signed({1'b0, med_ff}) - $signed({1'b0, last_ff});
      gain_s = $signed({1'b0, cfg.follow_gain});

      step = prod_ff[23:8];
      sum = $signed({5'b0, last_ff}) + $signed({{2{step[15]}}, step});
      if (sum < 0) begin
         sat = '0;
      end else if (sum > $signed({5'b0, ems_pkg::DIST_LIMIT})) begin
         sat = ems_pkg::DIST_LIMIT;
      end else begin
         sat = sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && (state_ff == ST_POP) && take_sample) begin
         store_ff[kept_ff[PW-1:0]] <= pop_entry.distance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_POP;
         kept_ff <= '0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_POP: begin
               if (pop_valid) begin
                  if (pop_entry.last) begin
                     kept_ff <= '0;
                     cnt_ff <= kept_next;
                     idx_ff <= '0;
                     if (too_few) begin
                        result_ff <= last_ff;
                        held_ff <= 1'b1;
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_RANK;
                     end
                  end else begin
                     kept_ff <= kept_next;
                  end
               end
            end
            ST_RANK: begin
               if (rank == (cnt_ff >> 1)) begin
                  med_ff <= cand;
               end
               idx_ff <= idx_ff + PW'(1);
               if (rank_done) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= diff * gain_s;
               bypass_ff <= (last_ff == '0) || (mag <= cfg.spike_threshold);
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               result_ff <= bypass_ff ? med_ff : sat;
               last_ff <= bypass_ff ? med_ff : sat;
               held_ff <= 1'b0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_distance_ff <= result_ff;
                  rsp_held_ff <= held_ff;
                  rsp_count_ff <= 3'(cnt_ff);
                  state_ff <= ST_POP;
               end
            end
            default: begin
               state_ff <= ST_POP;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_held = rsp_held_ff;
   assign rsp_valid_count = rsp_count_ff;

endmodule

FILE: tb/echo_median_spike_limiter_core_tb.sv
// Self-checking testbench of the echo median spike limiter with its own filter predictor.
module echo_median_spike_limiter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GROUP_LEN = 7;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES = 11;

   typedef struct packed {
      logic [ems_pkg::DIST_W-1:0] distance;
      logic                       held;
      logic [2:0]                 count;
   } reading_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [ems_pkg::ECHO_W-1:0]     req_echo_us = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [ems_pkg::DIST_W-1:0]     rsp_distance;
   logic                           rsp_held;
   logic [2:0]                     rsp_valid_count;
   logic                           csr_we = 1'b0;
   logic [ems_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ems_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   ems_pkg::cfg_type           shadow_cfg;
   logic [ems_pkg::DIST_W-1:0] kept_samples[GROUP_LEN];
   int unsigned                kept_n = 0;
   int unsigned                group_pos = 0;
   logic [ems_pkg::DIST_W-1:0] last_dist = '0;

   logic [ems_pkg::ECHO_W-1:0] echo_backlog[$];
   reading_type                expected_readings[$];
   int                         req_beats_offered = 0;
   int                         req_beats_taken = 0;
   int                         req_gap = 0;
   int                         rsp_gap = 0;
   bit                         bursts_on = 1'b1;
   int                         failures = 0;
   int                         cycle_count = 0;
   int                         echo_aim = 1000;

   echo_median_spike_limiter_core #(
      .SAMPLES_PER_GROUP(GROUP_LEN)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_echo_us(req_echo_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance),
      .rsp_held(rsp_held),
      .rsp_valid_count(rsp_valid_count),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void stash_echo(input logic [ems_pkg::ECHO_W-1:0] echo);
      echo_backlog = {echo_backlog, echo};
   endfunction

   function automatic void fold_echo(input logic [ems_pkg::ECHO_W-1:0] echo);
      int unsigned echo_wide;
      int unsigned conv_d;
      int unsigned sorted_d[GROUP_LEN];
      int unsigned probe;
      int          i;
      int          j;
      longint      median;
      longint      prior;
      longint      gain;
      longint      pull;
      longint      level;
      reading_type outcome;
      echo_wide = echo;
      conv_d = (echo_wide * ems_pkg::DIST_SCALE) >> ems_pkg::DIST_SHIFT;
      if (conv_d > shadow_cfg.min_distance && conv_d < shadow_cfg.max_distance &&
          kept_n < GROUP_LEN) begin
         kept_samples[kept_n] = conv_d[ems_pkg::DIST_W-1:0];
         kept_n++;
      end
      group_pos++;
      if (group_pos < GROUP_LEN)
         return;
      outcome.count = kept_n[2:0];
      if (kept_n == 0 || kept_n < shadow_cfg.min_valid) begin
         outcome.distance = last_dist;
         outcome.held = 1'b1;
      end else begin
         for (i = 0; i < kept_n; i++)
            sorted_d[i] = kept_samples[i];
         for (i = 1; i < kept_n; i++) begin
            probe = sorted_d[i];
            j = i;
            while (j > 0 && sorted_d[j-1] > probe) begin
               sorted_d[j] = sorted_d[j-1];
               j--;
            end
            sorted_d[j] = probe;
         end
         median = sorted_d[kept_n / 2];
         prior = last_dist;
         gain = shadow_cfg.follow_gain;
         level = median;
         if (prior != 0 && (median > prior ? median - prior : prior - median) >
             shadow_cfg.spike_threshold) begin
            // The damped step is floored, so downward steps round away from zero.
            pull = ((median - prior) * gain) >>> 8;
            level = prior + pull;
            if (level < 0)
               level = 0;
            if (level > ems_pkg::DIST_LIMIT)
               level = ems_pkg::DIST_LIMIT;
         end
         last_dist = level[ems_pkg::DIST_W-1:0];
         outcome.distance = level[ems_pkg::DIST_W-1:0];
         outcome.held = 1'b0;
      end
      kept_n = 0;
      group_pos = 0;
      expected_readings = {expected_readings, outcome};
   endfunction

   function automatic logic [ems_pkg::ECHO_W-1:0] echo_for_distance(input int target);
      int echo;
      if (target < 0)
         target = 0;
      echo = (target * 4096 + 1113) / 1114;
      if (echo > 32767)
         echo = 32767;
      return echo[ems_pkg::ECHO_W-1:0];
   endfunction

   task automatic write_register(input logic [ems_pkg::CSR_IDX_W-1:0] idx,
                                 input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[ems_pkg::CSR_DATA_W-1:0];
      case (idx)
         ems_pkg::CSR_MIN_DISTANCE:
            shadow_cfg.min_distance = value[ems_pkg::DIST_W-1:0];
         ems_pkg::CSR_MAX_DISTANCE:
            shadow_cfg.max_distance = value[ems_pkg::DIST_W-1:0];
         ems_pkg::CSR_SPIKE_THRESHOLD:
            shadow_cfg.spike_threshold = value[ems_pkg::DIST_W-1:0];
         ems_pkg::CSR_FOLLOW_GAIN:
            shadow_cfg.follow_gain = value[ems_pkg::GAIN_W-1:0];
         ems_pkg::CSR_MIN_VALID:
            shadow_cfg.min_valid = value[ems_pkg::MINV_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_limits(input int unsigned lo, input int unsigned hi,
                                 input int unsigned thr, input int unsigned gain,
                                 input int unsigned minv);
      write_register(ems_pkg::CSR_MIN_DISTANCE, lo);
      write_register(ems_pkg::CSR_MAX_DISTANCE, hi);
      write_register(ems_pkg::CSR_SPIKE_THRESHOLD, thr);
      write_register(ems_pkg::CSR_FOLLOW_GAIN, gain);
      write_register(ems_pkg::CSR_MIN_VALID, minv);
      @(posedge clock);
   endtask

   // Mostly echoes around a target that drifts or jumps once every GROUP_LEN echoes, with
   // timeouts, random noise and samples at or next to the configured bounds mixed in.
   task automatic queue_echoes(input int count);
      int k;
      int roll;
      int edge_dist;
      int echo;
      for (k = 0; k < count; k++) begin
         if (k % GROUP_LEN == 0) begin
            if ($urandom_range(0, 9) < 7)
               echo_aim = echo_aim + $urandom_range(0, 240) - 120;
            else
               echo_aim = $urandom_range(0, 6600);
            if (echo_aim < 0)
               echo_aim = 0;
            if (echo_aim > 8100)
               echo_aim = 8100;
         end
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            echo = 0;
         end else if (roll < 18) begin
            echo = $urandom_range(0, 32767);
         end else if (roll < 24) begin
            if ($urandom_range(0, 1) == 0)
               edge_dist = shadow_cfg.min_distance;
            else
               edge_dist = shadow_cfg.max_distance;
            echo = echo_for_distance(edge_dist + $urandom_range(0, 2) - 1);
         end else begin
            echo = echo_for_distance(echo_aim + $urandom_range(0, 60) - 30) +
                   $urandom_range(0, 2);
            if (echo > 32767)
               echo = 32767;
         end
         stash_echo(echo[ems_pkg::ECHO_W-1:0]);
      end
   endtask

   task automatic settle();
      while (echo_backlog.size() != 0 || req_beats_offered != req_beats_taken ||
             expected_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beats_offered == req_beats_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (echo_backlog.size() != 0) begin
            req_echo_us <= echo_backlog.pop_front();
            req_valid <= 1'b1;
            req_beats_offered++;
            if (bursts_on && $urandom_range(0, 5) == 0)
               req_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (bursts_on && $urandom_range(0, 7) == 0)
            rsp_gap = $urandom_range(1, 17);
      end
   end

   always @(posedge clock) begin
      reading_type due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            fold_echo(req_echo_us);
            req_beats_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $error("rsp beat with no reading expected: distance %0d", rsp_distance);
               failures++;
            end else begin
               due = expected_readings.pop_front();
               if (rsp_distance !== due.distance) begin
                  $error("distance: expected %0d, actual %0d", due.distance, rsp_distance);
                  failures++;
               end
               if (rsp_held !== due.held) begin
                  $error("held: expected %0d, actual %0d", due.held, rsp_held);
                  failures++;
               end
               if (rsp_valid_count !== due.count) begin
                  $error("valid_count: expected %0d, actual %0d", due.count,
                         rsp_valid_count);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      shadow_cfg.min_distance = ems_pkg::MIN_DISTANCE_RST;
      shadow_cfg.max_distance = ems_pkg::MAX_DISTANCE_RST;
      shadow_cfg.spike_threshold = ems_pkg::SPIKE_THRESHOLD_RST;
      shadow_cfg.follow_gain = ems_pkg::FOLLOW_GAIN_RST;
      shadow_cfg.min_valid = ems_pkg::MIN_VALID_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Timeout, oversized echo, both exclusive bounds: only two samples survive.
      stash_echo('0);
      stash_echo(15'h7fff);
      stash_echo(15'd30000);
      stash_echo(echo_for_distance(32));
      stash_echo(echo_for_distance(33));
      stash_echo(echo_for_distance(6399));
      stash_echo(echo_for_distance(6400));
      // A full group with no previous distance goes straight to the median.
      stash_echo(echo_for_distance(500));
      stash_echo(echo_for_distance(900));
      stash_echo(echo_for_distance(100));
      stash_echo(echo_for_distance(700));
      stash_echo(echo_for_distance(300));
      stash_echo(echo_for_distance(800));
      stash_echo(echo_for_distance(200));
      // A large jump with an even sample count is damped.
      stash_echo(echo_for_distance(3000));
      stash_echo(echo_for_distance(3010));
      stash_echo(echo_for_distance(2990));
      stash_echo(echo_for_distance(3020));
      stash_echo('0);
      stash_echo(echo_for_distance(2980));
      stash_echo(echo_for_distance(3005));
      settle();

      for (phase = 1; phase <= PHASES; phase++) begin
         case (phase)
            1: program_limits(0, 8191, 0, 256, 1);
            2: program_limits(2000, 2100, 8191, 0, 7);
            3: program_limits(4000, 1000, 80, 179, 3);
            4: program_limits(32, 6400, 80, 511, 0);
            PHASES: program_limits(32, 6400, 80, 179, 3);
            default: begin
               if ($urandom_range(0, 4) != 0)
                  program_limits($urandom_range(0, 1000), $urandom_range(3000, 8191),
                                 $urandom_range(0, 600), $urandom_range(0, 300),
                                 $urandom_range(1, 7));
               else
                  program_limits($urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(0, 8191));
            end
         endcase
         bursts_on = (phase % 3 != 2) && (phase != PHASES);
         queue_echoes($urandom_range(50, 90));
         settle();
      end

      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
